@@ sv/grid_clearance_map_assert.svh @@
// assertion macros used by the clearance map top level
// no dependencies; include by bare file name
`ifndef GRID_CLEARANCE_MAP_ASSERT_SVH
`define GRID_CLEARANCE_MAP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define GCM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("clearance map check failed");

// consequent holds in the cycle after the antecedent
`define GCM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("clearance map check failed");

`endif

@@ sv/gcm_pkg.sv @@
// types, constants and clearance arithmetic for the clearance map
// no dependencies
`timescale 1ns / 1ps

package gcm_pkg;

   localparam int FIELD_W   = 3;
   localparam int NUM_FIELD = 5;
   localparam int WORD_W    = FIELD_W * NUM_FIELD;
   localparam int BORDER    = 2;
   localparam int X_W       = 10;
   localparam int Y_W       = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   localparam logic [FIELD_W-1:0] LIMIT_RESET = 3'd5;
   localparam logic [X_W-1:0]     WIDTH_LAST_RESET  = 10'd63;
   localparam logic [Y_W-1:0]     HEIGHT_LAST_RESET = 12'd63;

   // field order inside a clearance word, lowest bits first
   localparam int F_WALK  = 0;
   localparam int F_WATER = 1;
   localparam int F_DEEP  = 2;
   localparam int F_AMPHI = 3;
   localparam int F_AIR   = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAP_WIDTH   = 2'd0,
      REG_MAP_HEIGHT  = 2'd1,
      REG_CLEAR_LIMIT = 2'd2
   } csr_index_type;

   typedef logic [FIELD_W-1:0] clear_type;
   typedef logic [WORD_W-1:0]  word_type;

   // one more than the smallest neighbour, saturated at the limit
   function automatic clear_type clear_field(clear_type south, clear_type southeast,
                                             clear_type east, clear_type limit);
      clear_type           m;
      logic [FIELD_W:0]    inc;
      m = south;
      if (southeast < m) m = southeast;
      if (east < m) m = east;
      inc = {1'b0, m} + {{FIELD_W{1'b0}}, 1'b1};
      if (inc > {1'b0, limit}) inc = {1'b0, limit};
      return inc[FIELD_W-1:0];
   endfunction

endpackage

@@ sv/gcm_line_store.sv @@
// line store holding the previous row of clearance words
// depends on gcm_pkg for the word width
`timescale 1ns / 1ps

module gcm_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                      clock,
   input  logic                      write_en,
   input  logic [AW-1:0]             write_addr,
   input  logic [gcm_pkg::WORD_W-1:0] write_data,
   input  logic [AW-1:0]             read_addr,
   output logic [gcm_pkg::WORD_W-1:0] read_data_ff
);

   logic [gcm_pkg::WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_addr];
   end

endmodule

@@ sv/grid_clearance_map.sv @@
// clearance map top level: scan counters, neighbour registers, result register
// depends on gcm_pkg, gcm_line_store and grid_clearance_map_assert.svh
//
// channel  dir  handshake                payload
// req      in   req_tvalid/req_tready    tdata: surface_blocked, submerged, deep_submerged
// rsp      out  rsp_tvalid/rsp_tready    tdata: cell_x, cell_y, five clearances
// csr      in   csr_valid/csr_ready      csr_index, csr_data
//
// one cell per cycle unless rsp stalls; east neighbour feeds back via min and increment
// the line store is read at the next column's address and registered, so no read waits
// a result sits in one output register; req_tready stays high while it drains
// synchronous reset restores 64 x 64, limit 5, scan at the south-east corner
`timescale 1ns / 1ps
`include "grid_clearance_map_assert.svh"

module grid_clearance_map #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // surface_blocked, submerged, deep_submerged, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cell_x, cell_y, walk, water, deep, amphi, air, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [gcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcm_pkg::CSR_DAT_W-1:0] csr_data
);

   localparam int DEPTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [10:0] CAP_W = 11'(DEPTH);

   localparam int FW = gcm_pkg::FIELD_W;
   localparam int XW = gcm_pkg::X_W;
   localparam int YW = gcm_pkg::Y_W;

   logic [XW-1:0] w_last_ff, w_last_in;
   logic [YW-1:0] h_last_ff, h_last_in;
   logic [FW-1:0] limit_ff, limit_in;
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   gcm_pkg::word_type east_ff, east_in;
   gcm_pkg::word_type se_ff, se_in;
   gcm_pkg::word_type south;
   gcm_pkg::word_type result;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]     rsp_x_ff;
   logic [YW-1:0]     rsp_y_ff;
   gcm_pkg::word_type rsp_word_ff;

   logic accept;
   logic csr_we;
   logic inner;
   logic restart;
   logic [10:0] w_sat;
   logic [12:0] h_sat;
   logic [4:0]  blocked;
   logic sb, sub, deep;
   gcm_pkg::csr_index_type csr_sel;

   assign csr_ready  = 1'b1;
   assign csr_we     = csr_valid && csr_ready;
   assign csr_sel    = gcm_pkg::csr_index_type'(csr_index);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign sb   = req_tdata[0];
   assign sub  = req_tdata[1];
   assign deep = req_tdata[2];

   // geometry saturation on the write data
   always_comb begin
      if (csr_data[10:0] < 11'd3) begin
         w_sat = 11'd3;
      end else if (csr_data[10:0] > CAP_W) begin
         w_sat = CAP_W;
      end else begin
         w_sat = csr_data[10:0];
      end
      if (csr_data < 13'd3) begin
         h_sat = 13'd3;
      end else if (csr_data > 13'd4096) begin
         h_sat = 13'd4096;
      end else begin
         h_sat = csr_data;
      end
   end

   // register writes
   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      limit_in  = limit_ff;
      restart   = 1'b0;
      if (csr_we) begin
         unique case (csr_sel)
            gcm_pkg::REG_MAP_WIDTH: begin
               w_last_in = XW'(w_sat - 11'd1);
               restart   = 1'b1;
            end
            gcm_pkg::REG_MAP_HEIGHT: begin
               h_last_in = YW'(h_sat - 13'd1);
               restart   = 1'b1;
            end
            gcm_pkg::REG_CLEAR_LIMIT: begin
               limit_in = (csr_data[FW-1:0] == '0) ? FW'(1) : csr_data[FW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // clearance of the current cell
   assign inner = (({1'b0, col_ff} + 11'd1) < {1'b0, w_last_ff}) &&
                  (({1'b0, row_ff} + 13'd1) < {1'b0, h_last_ff});

   assign blocked[gcm_pkg::F_WALK]  = sb | deep;
   assign blocked[gcm_pkg::F_WATER] = sb | ~sub;
   assign blocked[gcm_pkg::F_DEEP]  = sb | ~deep;
   assign blocked[gcm_pkg::F_AMPHI] = sb;
   assign blocked[gcm_pkg::F_AIR]   = 1'b0;

   always_comb begin
      for (int f = 0; f < gcm_pkg::NUM_FIELD; f++) begin
         if (inner && !blocked[f]) begin
            result[f*FW +: FW] = gcm_pkg::clear_field(south[f*FW +: FW], se_ff[f*FW +: FW],
                                                      east_ff[f*FW +: FW], limit_ff);
         end else begin
            result[f*FW +: FW] = '0;
         end
      end
   end

   // scan counters and neighbour registers
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      east_in = east_ff;
      se_in   = se_ff;
      if (restart) begin
         col_in  = w_last_in;
         row_in  = h_last_in;
         east_in = '0;
         se_in   = '0;
      end else if (accept) begin
         east_in = result;
         se_in   = south;
         if (col_ff == '0) begin
            col_in = w_last_ff;
            row_in = (row_ff == '0) ? h_last_ff : row_ff - YW'(1);
         end else begin
            col_in = col_ff - XW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= gcm_pkg::WIDTH_LAST_RESET;
         h_last_ff    <= gcm_pkg::HEIGHT_LAST_RESET;
         limit_ff     <= gcm_pkg::LIMIT_RESET;
         col_ff       <= gcm_pkg::WIDTH_LAST_RESET;
         row_ff       <= gcm_pkg::HEIGHT_LAST_RESET;
         east_ff      <= '0;
         se_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         limit_ff     <= limit_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         east_ff      <= east_in;
         se_ff        <= se_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_x_ff    <= col_ff;
         rsp_y_ff    <= row_ff;
         rsp_word_ff <= result;
      end
   end

   // read address runs one column ahead of the cell being accepted
   gcm_line_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_line_store (
      .clock        (clock),
      .write_en     (accept),
      .write_addr   (col_ff[AW-1:0]),
      .write_data   (result),
      .read_addr    (col_in[AW-1:0]),
      .read_data_ff (south)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_word_ff, rsp_y_ff, rsp_x_ff};

   `GCM_ASSERT_ALWAYS(a_col_range, clock, reset, col_ff <= w_last_ff)
   `GCM_ASSERT_ALWAYS(a_row_range, clock, reset, row_ff <= h_last_ff)
   `GCM_ASSERT_ALWAYS(a_limit_nonzero, clock, reset, limit_ff != '0)
   `GCM_ASSERT_NEXT(a_border_zero, clock, reset, accept && !inner, rsp_word_ff == '0)
   `GCM_ASSERT_NEXT(a_col_step, clock, reset, accept && !restart && col_ff != '0, col_ff == $past(col_ff) - XW'(1))

endmodule

@@ test/tb.sv @@
// testbench for grid_clearance_map: streams flag cells through small and extreme
// maps and checks every clearance item against a predictor kept in step here
// depends on gcm_pkg and grid_clearance_map
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_ITEMS     = 620;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int END_PAUSE        = 20;
   localparam int MAX_PRINTED      = 40;
   localparam int XW               = gcm_pkg::X_W;
   localparam int YW               = gcm_pkg::Y_W;
   localparam int FW               = gcm_pkg::FIELD_W;
   localparam int NF               = gcm_pkg::NUM_FIELD;
   localparam int IDX_W            = gcm_pkg::CSR_IDX_W;
   localparam int DAT_W            = gcm_pkg::CSR_DAT_W;
   localparam int CLEAR_LSB        = XW + YW;

   localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic deep_submerged;
      logic submerged;
      logic surface_blocked;
   } cell_flags_type;

   typedef struct packed {
      logic [XW-1:0]            cell_x;
      logic [YW-1:0]            cell_y;
      logic [NF-1:0][FW-1:0]    clear;
   } cell_clearance_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;   // surface_blocked, submerged, deep_submerged, pad
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;         // cell_x, cell_y, walk, water, deep, amphi, air, pad
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index  = '0;
   logic [DAT_W-1:0] csr_data   = '0;

   // predictor state
   gcm_pkg::word_type  prev_row [0:1023];
   gcm_pkg::word_type  east_word  = '0;
   gcm_pkg::word_type  se_word    = '0;
   logic [XW-1:0]      col_pos    = gcm_pkg::WIDTH_LAST_RESET;
   logic [YW-1:0]      row_pos    = gcm_pkg::HEIGHT_LAST_RESET;
   logic [10:0]        cfg_width  = 11'd64;
   logic [12:0]        cfg_height = 13'd64;
   gcm_pkg::clear_type cfg_limit  = gcm_pkg::LIMIT_RESET;

   cell_clearance_type pending_clearances [$];
   string              clear_name [NF] = '{"walk", "water", "deep", "amphi", "air"};

   int  fail_count  = 0;
   int  cycle_count = 0;
   int  hold_asked  = 0;
   int  hold_served = 0;
   bit  idle_on     = 1'b1;

   grid_clearance_map DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTED) $display("mismatch: %s", msg);
   endtask

   function automatic int unsigned map_cols();
      if (cfg_width < 11'd3) return 3;
      if (cfg_width > 11'd1024) return 1024;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned map_rows();
      if (cfg_height < 13'd3) return 3;
      if (cfg_height > 13'd4096) return 4096;
      return 32'(cfg_height);
   endfunction

   task automatic predict_clearance(input cell_flags_type flags);
      int unsigned          lim;
      int unsigned          inc;
      int                   f;
      logic [NF-1:0]        blocked;
      gcm_pkg::word_type    south;
      gcm_pkg::word_type    word;
      gcm_pkg::clear_type   m;
      cell_clearance_type   r;
      lim = (cfg_limit == '0) ? 1 : 32'(cfg_limit);
      south = prev_row[col_pos];
      word = '0;
      blocked[gcm_pkg::F_WALK]  = flags.surface_blocked | flags.deep_submerged;
      blocked[gcm_pkg::F_WATER] = flags.surface_blocked | ~flags.submerged;
      blocked[gcm_pkg::F_DEEP]  = flags.surface_blocked | ~flags.deep_submerged;
      blocked[gcm_pkg::F_AMPHI] = flags.surface_blocked;
      blocked[gcm_pkg::F_AIR]   = 1'b0;
      if (row_pos < map_rows() - gcm_pkg::BORDER && col_pos < map_cols() - gcm_pkg::BORDER) begin
         for (f = 0; f < NF; f++) begin
            if (!blocked[f]) begin
               m = south[f*FW +: FW];
               if (se_word[f*FW +: FW] < m) m = se_word[f*FW +: FW];
               if (east_word[f*FW +: FW] < m) m = east_word[f*FW +: FW];
               inc = 32'(m) + 1;
               word[f*FW +: FW] = gcm_pkg::clear_type'((inc > lim) ? lim : inc);
            end
         end
      end
      se_word = south;
      east_word = word;
      prev_row[col_pos] = word;
      r.cell_x = col_pos;
      r.cell_y = row_pos;
      for (f = 0; f < NF; f++) r.clear[f] = word[f*FW +: FW];
      pending_clearances.insert(pending_clearances.size(), r);
      if (col_pos == '0) begin
         col_pos = XW'(map_cols() - 1);
         if (row_pos == '0) row_pos = YW'(map_rows() - 1);
         else row_pos = row_pos - 1'b1;
      end else begin
         col_pos = col_pos - 1'b1;
      end
   endtask

   task automatic send_cell(input cell_flags_type flags);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, flags};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_clearance(flags);
   endtask

   task automatic wait_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_clearances.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high so that writes can follow back to back
   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         gcm_pkg::REG_MAP_WIDTH:   cfg_width = value[10:0];
         gcm_pkg::REG_MAP_HEIGHT:  cfg_height = value[12:0];
         gcm_pkg::REG_CLEAR_LIMIT: cfg_limit = value[FW-1:0];
         default: ;
      endcase
      if (idx == gcm_pkg::REG_MAP_WIDTH || idx == gcm_pkg::REG_MAP_HEIGHT) begin
         col_pos = XW'(map_cols() - 1);
         row_pos = YW'(map_rows() - 1);
         east_word = '0;
         se_word = '0;
      end
   endtask

   task automatic configure_map(input logic [DAT_W-1:0] w, input logic [DAT_W-1:0] h,
                                input logic [DAT_W-1:0] lim, input bit with_geometry);
      wait_idle();
      if (with_geometry) begin
         write_csr(gcm_pkg::REG_MAP_WIDTH, w);
         write_csr(gcm_pkg::REG_MAP_HEIGHT, h);
      end
      write_csr(gcm_pkg::REG_CLEAR_LIMIT, lim);
      if ($urandom_range(0, 7) == 0) write_csr(REG_SPARE, DAT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // result checking
   always @(posedge clock) begin : rsp_check
      cell_clearance_type want;
      int                 f;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_clearances.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, tdata %h", rsp_tdata));
         end else begin
            want = pending_clearances.pop_front();
            if (rsp_tdata[XW-1:0] != want.cell_x)
               report_mismatch($sformatf("cell_x got %0d want %0d",
                                         rsp_tdata[XW-1:0], want.cell_x));
            if (rsp_tdata[XW +: YW] != want.cell_y)
               report_mismatch($sformatf("cell_y got %0d want %0d",
                                         rsp_tdata[XW +: YW], want.cell_y));
            for (f = 0; f < NF; f++) begin
               if (rsp_tdata[CLEAR_LSB + f*FW +: FW] != want.clear[f])
                  report_mismatch($sformatf("%s at (%0d,%0d) got %0d want %0d",
                                            clear_name[f], want.cell_x, want.cell_y,
                                            rsp_tdata[CLEAR_LSB + f*FW +: FW],
                                            want.clear[f]));
            end
         end
      end
   end

   // receiver pacing: random stall bursts and the long hold-off
   initial begin : rsp_pacing
      int unsigned gap;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_served = hold_served + 1;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_reset_defaults();
      send_cell('{deep_submerged: 1'b0, submerged: 1'b0, surface_blocked: 1'b1});
      send_cell('{deep_submerged: 1'b1, submerged: 1'b1, surface_blocked: 1'b0});
      send_cell('{deep_submerged: 1'b0, submerged: 1'b0, surface_blocked: 1'b0});
   endtask

   task automatic test_geometry_extremes();
      configure_map(13'd1024, 13'd4096, 13'd7, 1'b1);
      repeat (3) send_cell(cell_flags_type'(3'b000));
      // width is masked, then saturated; height is saturated; limit zero acts as one
      configure_map(13'h1FFF, 13'h1FFF, 13'h1FF8, 1'b1);
      send_cell(cell_flags_type'(3'b111));
   endtask

   task automatic test_smallest_map();
      int unsigned i;
      configure_map(13'd0, 13'd1, 13'd0, 1'b1);
      for (i = 0; i < 9; i++) send_cell(cell_flags_type'(i[2:0] + 3'd1));
      wait_idle();
      write_csr(REG_SPARE, 13'h1FFF);
      csr_valid <= 1'b0;
      for (i = 0; i < 9; i++) send_cell(cell_flags_type'(3'd7 - i[2:0] + 3'd2));
   endtask

   task automatic test_random_maps();
      int unsigned    done_items;
      int unsigned    n;
      int unsigned    w;
      int unsigned    h;
      int unsigned    kind;
      int unsigned    sb_pct;
      int unsigned    sub_pct;
      int unsigned    deep_pct;
      int unsigned    pct_choice [5];
      cell_flags_type flags;
      pct_choice = '{0, 10, 50, 90, 100};
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // raw register values, mostly large maps; mostly border cells are reached
            configure_map(DAT_W'($urandom), DAT_W'($urandom),
                          DAT_W'($urandom), 1'b1);
            n = $urandom_range(20, 60);
         end else if (kind == 9) begin
            // limit change only, the scan carries on where it stopped
            configure_map('0, '0, DAT_W'($urandom_range(0, 7)), 1'b0);
            n = $urandom_range(20, 120);
         end else begin
            w = (kind < 4) ? $urandom_range(9, 20) : $urandom_range(3, 12);
            h = $urandom_range(3, 14);
            configure_map(DAT_W'(w), DAT_W'(h),
                          DAT_W'($urandom_range(0, 7)), 1'b1);
            n = $urandom_range(0, 2) * w * h + $urandom_range(1, w * h);
            if (n > 300) n = 300;
         end
         if ($urandom_range(0, 4) == 0) begin
            sb_pct = 50;
            sub_pct = 50;
            deep_pct = 50;
         end else begin
            sb_pct = pct_choice[$urandom_range(0, 2)];
            sub_pct = pct_choice[$urandom_range(0, 4)];
            deep_pct = pct_choice[$urandom_range(0, 4)];
         end
         repeat (n) begin
            flags.surface_blocked = ($urandom_range(0, 99) < sb_pct);
            flags.submerged = ($urandom_range(0, 99) < sub_pct);
            flags.deep_submerged = ($urandom_range(0, 99) < deep_pct);
            send_cell(flags);
         end
         done_items += n;
      end
   endtask

   task automatic test_backpressure();
      cell_flags_type flags;
      configure_map(13'd12, 13'd12, 13'd7, 1'b1);
      idle_on = 1'b0;
      hold_asked = hold_asked + 1;
      repeat (144) begin
         flags = cell_flags_type'(3'($urandom_range(0, 7)));
         flags.surface_blocked = ($urandom_range(0, 9) == 0);
         send_cell(flags);
      end
      // sender pauses until every pending item has come back
      wait_idle();
      idle_on = 1'b1;
   endtask

   task automatic test_steady_stream();
      configure_map(13'd16, 13'd10, DAT_W'($urandom_range(0, 7)), 1'b1);
      idle_on = 1'b0;
      repeat (160) send_cell(cell_flags_type'(3'($urandom_range(0, 7))));
   endtask

   initial begin
      foreach (prev_row[i]) prev_row[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_geometry_extremes();
      test_smallest_map();
      test_random_maps();
      test_backpressure();
      test_steady_stream();
      wait_idle();
      repeat (END_PAUSE) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
